// ----- hdl/mni_pkg.sv -----
// Package for the modal Newmark integrator: sizes, codes, types and
// Q16.16 helper functions. No dependencies.
package mni_pkg;
    localparam int NUM_MODES = 8;
    localparam int MODE_W    = 3;
    localparam int Q_W       = 32;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_INIT = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = -32'sh7FFFFFFF - 32'sh1;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        logic       start;
        logic       neg;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic signed [31:0] quo;
        logic        ovf;
    } div_rsp_t;

    function automatic q_t sat33(input logic signed [32:0] x, inout logic fl);
        if (x > 33'sd2147483647)
        begin
            fl = 1'b1;
            return Q_MAX;
        end
        if (x < -33'sd2147483648)
        begin
            fl = 1'b1;
            return Q_MIN;
        end
        return x[31:0];
    endfunction

    function automatic q_t sat64(input logic signed [63:0] x, inout logic fl);
        if (x > 64'sd2147483647)
        begin
            fl = 1'b1;
            return Q_MAX;
        end
        if (x < -64'sd2147483648)
        begin
            fl = 1'b1;
            return Q_MIN;
        end
        return x[31:0];
    endfunction
endpackage

// ----- hdl/mni_if.sv -----
// Valid/ready channel interfaces for the modal Newmark integrator.
// Depends on mni_pkg.
interface mni_in_if import mni_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  mode_index;
    logic [30:0] time_step;
    logic signed [31:0] fluid_force;
    logic signed [31:0] modal_mass;
    logic signed [31:0] modal_stiffness;
    logic signed [31:0] modal_damping;
    logic signed [31:0] start_speed;
    modport source (output valid, command, mode_index, time_step, fluid_force,
                    modal_mass, modal_stiffness, modal_damping, start_speed,
                    input ready);
    modport sink (input valid, command, mode_index, time_step, fluid_force,
                  modal_mass, modal_stiffness, modal_damping, start_speed,
                  output ready);
endinterface

interface mni_out_if import mni_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  result_mode;
    logic signed [31:0] result_speed;
    logic        last_of_run;
    logic        overflow;
    modport source (output valid, result_mode, result_speed, last_of_run, overflow,
                    input ready);
    modport sink (input valid, result_mode, result_speed, last_of_run, overflow,
                  output ready);
endinterface

interface mni_cfg_if ();
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/mni_div.sv -----
// Restoring divider for Q16.16 quotients, one quotient bit a cycle.
// Depends on mni_pkg.
module mni_div import mni_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [47:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, neg_reg, neg_next, zero_reg, zero_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic signed [49:0] sq;
    logic        fl;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], num_reg[47]};
        if (req.start)
        begin
            num_next  = {req.num, 16'd0};
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd48;
            busy_next = (req.den != 32'd0);
            done_next = (req.den == 32'd0);
            neg_next  = req.neg;
            zero_next = (req.den == 32'd0);
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[46:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        fl = 1'b0;
        sq = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        rsp.done = done_reg;
        if (zero_reg)
        begin
            rsp.quo = neg_reg ? Q_MIN : Q_MAX;
            fl = 1'b1;
        end
        else
            rsp.quo = sat64(64'(sq), fl);
        rsp.ovf = fl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end
endmodule

// ----- hdl/modal_newmark_integrator.sv -----
// Top level of the modal Newmark integrator: sequencer, shared Q16.16
// multiply/add unit and state. Depends on mni_pkg, mni_if, mni_div.
//
// Usage: in channel takes command words. A load word writes one mode's
// mass, stiffness and damping; an initialize word sets every speed to
// start_speed and clears acceleration and displacement; a step word
// advances every mode by one Newmark step and emits one out word per
// mode in mode order, the last marked by last_of_run. cfg writes
// scheme_select (0 explicit half-step, 1 implicit average acceleration)
// and is taken only while idle.
// A step word passes one setup state, then per mode 5 (explicit) or 8
// (implicit) operations, a bit-serial divide (cut short on a zero
// divisor), 1 or 5 update operations and an emit state. A new in word
// is accepted only once the sequencer is back in idle.
// Reset clears the state and scheme_select. When out stalls, the
// sequencer holds in the emit state with the result in res_reg.
module modal_newmark_integrator import mni_pkg::*; (
    input logic clk,
    input logic rst_n,
    mni_in_if.sink   in_ch,
    mni_out_if.source out_ch,
    mni_cfg_if.sink  cfg
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_OPS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;
    localparam logic [2:0] ST_PRE  = 3'd6;

    q_t m_mem [NUM_MODES];
    q_t k_mem [NUM_MODES];
    q_t c_mem [NUM_MODES];
    q_t v_mem [NUM_MODES];
    q_t a_mem [NUM_MODES];
    q_t x_mem [NUM_MODES];

    logic [2:0] st_reg, st_next;
    logic [MODE_W-1:0] md_reg;
    logic [4:0] op_reg;
    logic scheme_reg, sch_reg;
    q_t dt_reg, h_reg, f_reg, s_reg, sv_reg;
    logic sflag_reg, fl_reg;
    q_t t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    q_t res_reg;
    logic ov_valid_reg;
    logic [MODE_W-1:0] ov_mode_reg;
    q_t ov_speed_reg;
    logic ov_last_reg, ov_ovf_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    // shared unit operands
    q_t ma, mb, aa, ab;
    logic sub_op;
    logic signed [63:0] prod;
    logic signed [32:0] asum;
    q_t mres, ares;
    logic mfl, afl;
    q_t mm, kk, cc, vv, aa_s, xx;

    assign mm = m_mem[md_reg];
    assign kk = k_mem[md_reg];
    assign cc = c_mem[md_reg];
    assign vv = v_mem[md_reg];
    assign aa_s = a_mem[md_reg];
    assign xx = x_mem[md_reg];

    // op schedule: each op does res = sat(aa +/- sat(ma*mb)>>16), a plain multiply or a plain add/subtract
    logic use_mul, use_add;
    always_comb
    begin
        ma = '0; mb = '0; aa = '0; ab = '0; sub_op = 1'b0;
        use_mul = 1'b1; use_add = 1'b1;
        if (!sch_reg)
        begin
            case (op_reg)
                5'd0: begin ma = h_reg; mb = aa_s; aa = vv; end
                5'd1: begin ma = dt_reg; mb = t0_reg; aa = xx; end
                5'd2: begin ma = cc; mb = t0_reg; aa = f_reg; sub_op = 1'b1; end
                5'd3: begin ma = kk; mb = t1_reg; aa = t2_reg; sub_op = 1'b1; end
                default: begin ma = h_reg; mb = cc; aa = mm; end
            endcase
        end
        else
        begin
            case (op_reg)
                5'd0: begin ma = h_reg; mb = cc; aa = mm; end
                5'd1: begin ma = s_reg; mb = kk; aa = t0_reg; end
                5'd2: begin ma = h_reg; mb = aa_s; aa = vv; end
                5'd3: begin use_add = 1'b0; ma = cc; mb = t1_reg; end
                5'd4: begin ma = dt_reg; mb = vv; aa = xx; end
                5'd5: begin ma = s_reg; mb = aa_s; aa = t2_reg; end
                5'd6: begin ma = kk; mb = t2_reg; aa = t1_reg; end
                default: begin use_mul = 1'b0; aa = f_reg; ab = t2_reg; sub_op = 1'b1; end
            endcase
        end
    end

    always_comb
    begin
        mfl = 1'b0; afl = 1'b0;
        prod = ma * mb;
        mres = sat64(prod >>> 16, mfl);
        if (!use_mul)
            mres = ab;
        if (!use_mul)
            mfl = 1'b0;
        asum = sub_op ? ($signed({aa[31], aa}) - $signed({mres[31], mres}))
                      : ($signed({aa[31], aa}) + $signed({mres[31], mres}));
        ares = use_add ? sat33(asum, afl) : mres;
    end

    logic [5:0] n_ops;
    assign n_ops = sch_reg ? 6'd8 : 6'd5;

    // post-divide ops
    q_t pb, pres;
    logic pfl, pm;
    logic signed [63:0] pprod;
    logic signed [32:0] psum;
    q_t pm_res;
    always_comb
    begin
        pb = '0; pres = '0; pfl = 1'b0; pm = 1'b1;
        // explicit: op0: v=t0+h*a ; implicit: op0 asum=a+an (add), op1 dt*v,
        // op2 dx=s*asum + that, op3 x=x+dx, op4 v=v+h*asum
        pprod = '0; psum = '0; pm_res = '0;
        if (!sch_reg)
        begin
            pprod = h_reg * t4_reg;
            pm_res = sat64(pprod >>> 16, pfl);
            psum = $signed({t0_reg[31], t0_reg}) + $signed({pm_res[31], pm_res});
            pres = sat33(psum, pfl);
        end
        else
        begin
            case (op_reg)
                5'd0: begin pm = 1'b0;
                    psum = $signed({aa_s[31], aa_s}) + $signed({t4_reg[31], t4_reg});
                    pres = sat33(psum, pfl); end
                5'd1: begin pprod = dt_reg * vv; pres = sat64(pprod >>> 16, pfl); end
                5'd2: begin pprod = s_reg * t3_reg; pm_res = sat64(pprod >>> 16, pfl);
                    psum = $signed({t1_reg[31], t1_reg}) + $signed({pm_res[31], pm_res});
                    pres = sat33(psum, pfl); end
                5'd3: begin pm = 1'b0;
                    psum = $signed({xx[31], xx}) + $signed({t1_reg[31], t1_reg});
                    pres = sat33(psum, pfl); end
                default: begin pprod = h_reg * t3_reg;
                    pm_res = sat64(pprod >>> 16, pfl);
                    psum = $signed({vv[31], vv}) + $signed({pm_res[31], pm_res});
                    pres = sat33(psum, pfl); end
            endcase
        end
        pb = pres;
    end

    logic in_acc, out_free;
    logic signed [63:0] hh;
    q_t s_calc;
    logic s_fl;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign out_free = !ov_valid_reg || out_ch.ready;
    assign in_ch.ready = (st_reg == ST_IDLE);
    assign cfg.ready = (st_reg == ST_IDLE);

    always_comb
    begin
        s_fl = 1'b0;
        hh = h_reg * h_reg;
        s_calc = sat64(hh >>> 16, s_fl);
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.neg   = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        if (st_reg == ST_OPS && {1'b0, op_reg} == n_ops - 6'd1)
        begin
            dreq.start = 1'b1;
            if (!sch_reg)
            begin
                dreq.neg = t3_reg[31] ^ ares[31];
                dreq.num = t3_reg[31] ? 32'(-t3_reg) : t3_reg;
                dreq.den = ares[31] ? 32'(-ares) : ares;
                if (ares == 32'sd0)
                    dreq.neg = t3_reg[31];
            end
            else
            begin
                dreq.neg = ares[31] ^ t0_reg[31];
                dreq.num = ares[31] ? 32'(-ares) : ares;
                dreq.den = t0_reg[31] ? 32'(-t0_reg) : t0_reg;
                if (t0_reg == 32'sd0)
                    dreq.neg = ares[31];
            end
        end
    end

    mni_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (in_acc)
                begin
                    if (in_ch.command == CMD_INIT) st_next = ST_INIT;
                    else if (in_ch.command == CMD_STEP) st_next = ST_PRE;
                end
            ST_PRE:  st_next = ST_OPS;
            ST_INIT: if (md_reg == MODE_W'(NUM_MODES - 1)) st_next = ST_IDLE;
            ST_OPS:  if ({1'b0, op_reg} == n_ops - 6'd1) st_next = ST_DIV;
            ST_DIV:  if (drsp.done) st_next = ST_POST;
            ST_POST: if (!sch_reg || op_reg == 5'd4) st_next = ST_EMIT;
            ST_EMIT: if (out_free)
                st_next = (md_reg == MODE_W'(NUM_MODES - 1)) ? ST_IDLE : ST_OPS;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            md_reg <= '0;
            op_reg <= '0;
            scheme_reg <= 1'b0;
            ov_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MODES; i++)
            begin
                v_mem[i] <= '0;
                a_mem[i] <= '0;
                x_mem[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (cfg.valid && cfg.ready)
                scheme_reg <= cfg.data;
            if (st_reg == ST_EMIT && out_free)
                ov_valid_reg <= 1'b1;
            else if (out_ch.ready)
                ov_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    md_reg <= '0;
                    op_reg <= '0;
                    sch_reg <= scheme_reg;
                    if (in_acc)
                    begin
                        dt_reg <= {1'b0, in_ch.time_step};
                        h_reg <= {2'b00, in_ch.time_step[30:1]};
                        f_reg <= in_ch.fluid_force;
                        sv_reg <= in_ch.start_speed;
                    end
                end
                ST_PRE:
                begin
                    s_reg <= s_calc;
                    sflag_reg <= s_fl;
                    fl_reg <= sch_reg & s_fl;
                end
                ST_INIT:
                begin
                    v_mem[md_reg] <= sv_reg;
                    a_mem[md_reg] <= '0;
                    x_mem[md_reg] <= '0;
                    md_reg <= md_reg + MODE_W'(1);
                end
                ST_OPS:
                begin
                    fl_reg <= fl_reg | mfl | afl;
                    op_reg <= op_reg + 5'd1;
                    if (!sch_reg)
                        unique case (op_reg)
                            5'd0: t0_reg <= ares;
                            5'd1: t1_reg <= ares;
                            5'd2: t2_reg <= ares;
                            5'd3: t3_reg <= ares;
                            default: t4_reg <= ares;
                        endcase
                    else
                        unique case (op_reg)
                            5'd0: t0_reg <= ares;
                            5'd1: t0_reg <= ares;
                            5'd2: t1_reg <= ares;
                            5'd3: t1_reg <= ares;
                            5'd4: t2_reg <= ares;
                            5'd5: t2_reg <= ares;
                            5'd6: t2_reg <= ares;
                            default: t4_reg <= ares;
                        endcase
                end
                ST_DIV:
                begin
                    op_reg <= '0;
                    if (drsp.done)
                    begin
                        t4_reg <= drsp.quo;
                        fl_reg <= fl_reg | drsp.ovf;
                    end
                end
                ST_POST:
                begin
                    fl_reg <= fl_reg | pfl;
                    op_reg <= op_reg + 5'd1;
                    if (!sch_reg)
                    begin
                        x_mem[md_reg] <= t1_reg;
                        a_mem[md_reg] <= t4_reg;
                        v_mem[md_reg] <= pb;
                        res_reg <= t0_reg;
                    end
                    else
                        unique case (op_reg)
                            5'd0: t3_reg <= pb;
                            5'd1: t1_reg <= pb;
                            5'd2: t1_reg <= pb;
                            5'd3: x_mem[md_reg] <= pb;
                            default:
                            begin
                                v_mem[md_reg] <= pb;
                                a_mem[md_reg] <= t4_reg;
                                res_reg <= pb;
                            end
                        endcase
                end
                ST_EMIT:
                    if (out_free)
                    begin
                        ov_mode_reg <= md_reg;
                        ov_speed_reg <= res_reg;
                        ov_last_reg <= (md_reg == MODE_W'(NUM_MODES - 1));
                        ov_ovf_reg <= fl_reg;
                        md_reg <= md_reg + MODE_W'(1);
                        op_reg <= '0;
                        fl_reg <= sch_reg & sflag_reg;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_ch.command == CMD_LOAD && 32'(in_ch.mode_index) < NUM_MODES)
        begin
            m_mem[in_ch.mode_index] <= in_ch.modal_mass;
            k_mem[in_ch.mode_index] <= in_ch.modal_stiffness;
            c_mem[in_ch.mode_index] <= in_ch.modal_damping;
        end
    end

    assign out_ch.valid = ov_valid_reg;
    assign out_ch.result_mode = ov_mode_reg;
    assign out_ch.result_speed = ov_speed_reg;
    assign out_ch.last_of_run = ov_last_reg;
    assign out_ch.overflow = ov_ovf_reg;

    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("word dropped");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (st_reg == ST_DIV)) else $error("stray divide");
endmodule
